>>> hdl/mtd_pkg.sv
package mtd_pkg;

    localparam int NUM_BANDS_DEF   = 4;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IDX_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int ROM_ROWS        = 5;
    localparam logic [31:0] FOLLOW_INIT = 32'd2684355;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_DECAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_WEIGHT  = 3'd4;

    localparam logic [23:0] FAST_DECAY_RST   = 24'd16738629;
    localparam logic [23:0] SLOW_DECAY_RST   = 24'd16765591;
    localparam logic [23:0] SMOOTH_DECAY_RST = 24'd16718503;
    localparam logic [23:0] NORM_DECAY_RST   = 24'd16773473;
    localparam logic [15:0] SLOW_WEIGHT_RST  = 16'd52429;

    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_F0   = 5'd2;
    localparam logic [4:0] OP_F1   = 5'd3;
    localparam logic [4:0] OP_F2   = 5'd4;
    localparam logic [4:0] OP_F3   = 5'd5;
    localparam logic [4:0] OP_F4   = 5'd6;
    localparam logic [4:0] OP_B0   = 5'd7;
    localparam logic [4:0] OP_B1   = 5'd8;
    localparam logic [4:0] OP_B2   = 5'd9;
    localparam logic [4:0] OP_B3   = 5'd10;
    localparam logic [4:0] OP_B4   = 5'd11;
    localparam logic [4:0] OP_WGT  = 5'd12;
    localparam logic [4:0] OP_ENG  = 5'd13;
    localparam logic [4:0] OP_SF   = 5'd14;
    localparam logic [4:0] OP_NF   = 5'd15;
    localparam logic [4:0] OP_DIVI = 5'd16;
    localparam logic [4:0] OP_DIV  = 5'd17;
    localparam logic [4:0] OP_OUT  = 5'd18;

    typedef struct packed {
        logic [4:0]       op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Filter coefficients in Q4.28: b0, then a1 and a2 already negated.
    localparam logic signed [31:0] ROM_C0 [ROM_ROWS] = '{
        32'sd2638, 32'sd57961, 32'sd1201049, 32'sd19830188, 32'sd267245474};
    localparam logic signed [31:0] ROM_NC1 [ROM_ROWS] = '{
        32'sd534485673, 32'sd525598987, 32'sd483739509, 32'sd294696194,
        -32'sd534485673};
    localparam logic signed [31:0] ROM_NC2 [ROM_ROWS] = '{
        -32'sd266060768, -32'sd257395374, -32'sd220108248, -32'sd105581489,
        -32'sd266060768};

    function automatic int rom_row(input int f);
        return (f < ROM_ROWS) ? f : ROM_ROWS - 1;
    endfunction

endpackage

>>> hdl/mtd_controller.sv
module mtd_controller #(
    parameter int NUM_BANDS = mtd_pkg::NUM_BANDS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mtd_pkg::status_t status,
    output mtd_pkg::cmd_t    cmd
);
    import mtd_pkg::*;

    localparam int NUM_LP = NUM_BANDS + 1;
    localparam int LW     = $clog2(NUM_LP);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILT = 4'd1;
    localparam logic [3:0] ST_BAND = 4'd2;
    localparam logic [3:0] ST_WGT  = 4'd3;
    localparam logic [3:0] ST_ENG  = 4'd4;
    localparam logic [3:0] ST_SF   = 4'd5;
    localparam logic [3:0] ST_NF   = 4'd6;
    localparam logic [3:0] ST_DIVI = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [3:0]    dcnt_reg, dcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        cmd.op     = OP_NOP;
        cmd.idx    = IDX_W'(idx_reg);
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_FILT;
                    phase_next = '0;
                    idx_next   = '0;
                end
            end
            ST_FILT: begin
                case (phase_reg)
                    3'd0:    cmd.op = OP_F0;
                    3'd1:    cmd.op = OP_F1;
                    3'd2:    cmd.op = OP_F2;
                    3'd3:    cmd.op = OP_F3;
                    default: cmd.op = OP_F4;
                endcase
                if (phase_reg == 3'd4) begin
                    phase_next = '0;
                    if (idx_reg == LW'(NUM_LP - 1)) begin
                        state_next = ST_BAND;
                        idx_next   = LW'(1);
                    end else begin
                        idx_next = idx_reg + LW'(1);
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_BAND: begin
                case (phase_reg)
                    3'd0:    cmd.op = OP_B0;
                    3'd1:    cmd.op = OP_B1;
                    3'd2:    cmd.op = OP_B2;
                    3'd3:    cmd.op = OP_B3;
                    default: cmd.op = OP_B4;
                endcase
                if (phase_reg == 3'd4) begin
                    phase_next = '0;
                    if (idx_reg == LW'(NUM_BANDS)) begin
                        state_next = ST_WGT;
                    end else begin
                        idx_next = idx_reg + LW'(1);
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_WGT: begin
                cmd.op     = OP_WGT;
                state_next = ST_ENG;
            end
            ST_ENG: begin
                cmd.op     = OP_ENG;
                state_next = ST_SF;
            end
            ST_SF: begin
                cmd.op     = OP_SF;
                state_next = ST_NF;
            end
            ST_NF: begin
                cmd.op     = OP_NF;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.op     = OP_DIVI;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op    = OP_DIV;
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd15) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mtd_datapath.sv
module mtd_datapath #(
    parameter int NUM_BANDS   = mtd_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS = mtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mtd_pkg::cmd_t                       cmd,
    output mtd_pkg::status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0]       s_audio_sample,
    input  logic                                cfg_we,
    input  logic [mtd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_transient_level,
    output logic [30:0]                         m_raw_energy
);
    import mtd_pkg::*;

    localparam int NUM_LP = NUM_BANDS + 1;
    localparam int LW     = $clog2(NUM_LP);
    localparam int SUM_W  = 34 + $clog2(NUM_BANDS);
    localparam int SHIFT  = 29 - SAMPLE_BITS;

    logic signed [31:0] x_reg;
    logic signed [31:0] h0_reg [NUM_LP];
    logic signed [31:0] h1_reg [NUM_LP];
    logic signed [31:0] h2_reg [NUM_LP];
    logic signed [31:0] h3_reg [NUM_LP];
    logic signed [31:0] band_reg [NUM_LP];
    logic [31:0]        fpk_reg [NUM_LP];
    logic [31:0]        spk_reg [NUM_LP];
    logic signed [31:0] yprev_reg;
    logic signed [66:0] prod_reg, prod_next;
    logic signed [68:0] acc_reg;
    logic [SUM_W-1:0]   fsum_reg, ssum_reg;
    logic [SUM_W+15:0]  wprod_reg;
    logic [30:0]        e_reg, e_next;
    logic [31:0]        sf_reg, nf_reg;
    logic [32:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [23:0]        fd_reg, sd_reg, smd_reg, nd_reg;
    logic [15:0]        sw_reg;
    logic               m_valid_reg;
    logic [15:0]        level_reg, level_next;
    logic [30:0]        energy_reg;

    logic [LW-1:0]      ix;
    logic signed [33:0] xs;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] rnd;
    logic signed [31:0] y;
    logic signed [32:0] yd;
    logic signed [31:0] band_sat;
    logic [31:0]        dec;
    logic [31:0]        pk_new;
    logic [33:0]        sq;
    logic [SUM_W-1:0]   wsum, diff;
    logic [31:0]        fol_new;
    logic [32:0]        div_t;
    logic               div_ge;

    assign ix = cmd.idx[LW-1:0];
    assign xs = 34'(x_reg) + (34'(h0_reg[ix]) <<< 1) + 34'(h1_reg[ix]);

    // One shared multiplier serves the filters, the decays and the squares.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_F0: begin
                mul_a = xs;
                mul_b = 33'(ROM_C0[rom_row(int'(ix))]);
            end
            OP_F1: begin
                mul_a = 34'(h2_reg[ix]);
                mul_b = 33'(ROM_NC1[rom_row(int'(ix))]);
            end
            OP_F2: begin
                mul_a = 34'(h3_reg[ix]);
                mul_b = 33'(ROM_NC2[rom_row(int'(ix))]);
            end
            OP_B0: begin
                mul_a = {2'b00, fpk_reg[ix]};
                mul_b = {9'd0, fd_reg};
            end
            OP_B1: begin
                mul_a = {2'b00, spk_reg[ix]};
                mul_b = {9'd0, sd_reg};
            end
            OP_B2: begin
                mul_a = {2'b00, fpk_reg[ix]};
                mul_b = {1'b0, fpk_reg[ix]};
            end
            OP_B3: begin
                mul_a = {2'b00, spk_reg[ix]};
                mul_b = {1'b0, spk_reg[ix]};
            end
            OP_ENG: begin
                mul_a = {2'b00, sf_reg};
                mul_b = {9'd0, smd_reg};
            end
            OP_SF: begin
                mul_a = {2'b00, nf_reg};
                mul_b = {9'd0, nd_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 67'(mul_a) * 67'(mul_b);

    // Round half up to Q4.28, then saturate to 32 bits.
    assign rnd = (acc_reg + 69'sd134217728) >>> 28;
    always_comb begin
        if (rnd > 69'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (rnd < -69'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = rnd[31:0];
        end
    end

    assign yd = 33'(y) - 33'(yprev_reg);
    always_comb begin
        if (yd[32] != yd[31]) begin
            band_sat = yd[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            band_sat = yd[31:0];
        end
    end

    assign dec = prod_reg[55:24];
    assign pk_new = ($signed({band_reg[ix][31], band_reg[ix]}) > $signed({1'b0, dec}))
                    ? band_reg[ix] : dec;
    assign sq = prod_reg[61:28];

    assign wsum = wprod_reg[SUM_W+15:16];
    assign diff = (fsum_reg > wsum) ? fsum_reg - wsum : '0;
    assign e_next = (diff > SUM_W'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : diff[30:0];
    assign fol_new = ({1'b0, e_reg} > dec) ? {1'b0, e_reg} : dec;

    assign div_t  = {rem_reg[31:0], 1'b0};
    assign div_ge = div_t >= {1'b0, nf_reg};

    always_comb begin
        if (nf_reg == '0) begin
            level_next = '0;
        end else if (sf_reg >= nf_reg) begin
            level_next = 16'hFFFF;
        end else begin
            level_next = quo_reg;
        end
    end

    // Model state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LP; i++) begin
                h0_reg[i]  <= '0;
                h1_reg[i]  <= '0;
                h2_reg[i]  <= '0;
                h3_reg[i]  <= '0;
                fpk_reg[i] <= '0;
                spk_reg[i] <= '0;
            end
            sf_reg  <= FOLLOW_INIT;
            nf_reg  <= FOLLOW_INIT;
            fd_reg  <= FAST_DECAY_RST;
            sd_reg  <= SLOW_DECAY_RST;
            smd_reg <= SMOOTH_DECAY_RST;
            nd_reg  <= NORM_DECAY_RST;
            sw_reg  <= SLOW_WEIGHT_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FAST_DECAY:   fd_reg  <= cfg_data;
                    REG_SLOW_DECAY:   sd_reg  <= cfg_data;
                    REG_SMOOTH_DECAY: smd_reg <= cfg_data;
                    REG_NORM_DECAY:   nd_reg  <= cfg_data;
                    REG_SLOW_WEIGHT:  sw_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_F4: begin
                    h1_reg[ix] <= h0_reg[ix];
                    h0_reg[ix] <= x_reg;
                    h3_reg[ix] <= h2_reg[ix];
                    h2_reg[ix] <= y;
                end
                OP_B1:   fpk_reg[ix] <= pk_new;
                OP_B2:   spk_reg[ix] <= pk_new;
                OP_SF:   sf_reg <= fol_new;
                OP_NF:   nf_reg <= fol_new;
                default: ;
            endcase
        end
    end

    // Working registers of one sample.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD: begin
                x_reg    <= 32'(s_audio_sample) <<< SHIFT;
                fsum_reg <= '0;
                ssum_reg <= '0;
            end
            OP_F1: acc_reg <= 69'(prod_reg);
            OP_F2: acc_reg <= acc_reg + 69'(prod_reg);
            OP_F3: acc_reg <= acc_reg + 69'(prod_reg);
            OP_F4: begin
                yprev_reg <= y;
                if (ix != '0) begin
                    band_reg[ix] <= band_sat;
                end
            end
            OP_B3:   fsum_reg <= fsum_reg + SUM_W'(sq);
            OP_B4:   ssum_reg <= ssum_reg + SUM_W'(sq);
            OP_WGT:  wprod_reg <= ssum_reg * sw_reg;
            OP_ENG:  e_reg <= e_next;
            OP_DIVI: begin
                rem_reg <= {1'b0, sf_reg};
                quo_reg <= '0;
            end
            OP_DIV: begin
                rem_reg <= div_ge ? div_t - {1'b0, nf_reg} : div_t;
                quo_reg <= {quo_reg[14:0], div_ge};
            end
            OP_OUT: begin
                level_reg  <= level_next;
                energy_reg <= e_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free   = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_transient_level = level_reg;
    assign m_raw_energy      = energy_reg;

endmodule

>>> hdl/multiband_transient_detector_core.sv
// Multiband transient detector.
// Input channel s_valid/s_ready carries one signed audio sample per
// transaction; output channel m_valid/m_ready returns one result per sample:
// the transient level (Q0.16) and the clamped raw energy (Q4.28).
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle. The user must write them only while the block is
// idle; the block itself has no logic that enforces this. All filter taps,
// peak decays and squares go through one shared multiplier, and the level
// ratio uses a 16-step restoring divider. s_ready is high only while no sample
// is in progress, so a new sample is accepted only after the previous one is done.
// The result sits in an output register; a new sample may be accepted while
// it waits. If the receiver stalls, the next result waits at the end of its
// computation until the register is free.
// Reset clears filter history and band peaks, loads the energy followers
// with 0.01 and restores the default register values.
module multiband_transient_detector_core #(
    parameter int NUM_BANDS   = mtd_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS = mtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_audio_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_transient_level,
    output logic [30:0]                    m_raw_energy,
    input  logic                           cfg_we,
    input  logic [mtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtd_pkg::*;

    cmd_t    cmd;
    status_t status;

    mtd_controller #(
        .NUM_BANDS(NUM_BANDS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mtd_datapath #(
        .NUM_BANDS  (NUM_BANDS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_audio_sample    (s_audio_sample),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_transient_level (m_transient_level),
        .m_raw_energy      (m_raw_energy)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in progress");

    a_out_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> status.out_free)
        else $error("result written over an untaken result");

    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD) |-> (s_valid && s_ready))
        else $error("sample loaded without an input transaction");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mtd_pkg::*;

    localparam int NLP = 5;
    localparam int NB = 4;
    localparam int SETTLE = 120;
    localparam int PHASES = 8;
    localparam int PER_PHASE = 215;

    // Lowpass coefficients, Q4.28: b0, a1, a2 of each filter.
    localparam longint LP_B0 [NLP] = '{2638, 57961, 1201049, 19830188, 267245474};
    localparam longint LP_A1 [NLP] = '{-534485673, -525598987, -483739509, -294696194,
                                       534485673};
    localparam longint LP_A2 [NLP] = '{266060768, 257395374, 220108248, 105581489,
                                       266060768};

    class detector_scoreboard;
        longint hist [NLP][4];
        longint unsigned fast_pk [NB];
        longint unsigned slow_pk [NB];
        longint unsigned smooth_env, norm_env;
        longint unsigned decay_reg [4];
        longint unsigned weight;
        logic [15:0] level_q [$];
        logic [30:0] energy_q [$];
        int mismatches;

        function void clear();
            foreach (hist[i, j]) hist[i][j] = 0;
            foreach (fast_pk[i]) begin
                fast_pk[i] = 0;
                slow_pk[i] = 0;
            end
            smooth_env = FOLLOW_INIT;
            norm_env = FOLLOW_INIT;
            decay_reg[0] = FAST_DECAY_RST;
            decay_reg[1] = SLOW_DECAY_RST;
            decay_reg[2] = SMOOTH_DECAY_RST;
            decay_reg[3] = NORM_DECAY_RST;
            weight = SLOW_WEIGHT_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FAST_DECAY:   decay_reg[0] = data;
                REG_SLOW_DECAY:   decay_reg[1] = data;
                REG_SMOOTH_DECAY: decay_reg[2] = data;
                REG_NORM_DECAY:   decay_reg[3] = data;
                REG_SLOW_WEIGHT:  weight = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned track(longint unsigned pk, longint unsigned d, longint v);
            longint unsigned dec;
            dec = (pk * d) >> 24;
            return (v > longint'(dec)) ? longint'(v) : dec;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            longint x0, xs, acc, y, b;
            longint lp [NLP];
            longint unsigned fsum, ssum, wsum, e, lvl;
            x0 = longint'(smp) * 8192;
            for (int f = 0; f < NLP; f++) begin
                xs = x0 + 2 * hist[f][0] + hist[f][1];
                acc = LP_B0[f] * xs - LP_A1[f] * hist[f][2] - LP_A2[f] * hist[f][3];
                y = clip32((acc + 64'sd134217728) >>> 28);
                hist[f][1] = hist[f][0];
                hist[f][0] = x0;
                hist[f][3] = hist[f][2];
                hist[f][2] = y;
                lp[f] = y;
            end
            fsum = 0;
            ssum = 0;
            for (int i = 0; i < NB; i++) begin
                b = clip32(lp[i+1] - lp[i]);
                fast_pk[i] = track(fast_pk[i], decay_reg[0], b);
                slow_pk[i] = track(slow_pk[i], decay_reg[1], b);
                fsum += (fast_pk[i] * fast_pk[i]) >> 28;
                ssum += (slow_pk[i] * slow_pk[i]) >> 28;
            end
            wsum = (ssum * weight) >> 16;
            e = (fsum > wsum) ? fsum - wsum : 0;
            if (e > 64'h7FFFFFFF) e = 64'h7FFFFFFF;
            smooth_env = track(smooth_env, decay_reg[2], longint'(e));
            norm_env = track(norm_env, decay_reg[3], longint'(e));
            lvl = 0;
            if (norm_env != 0) begin
                lvl = (smooth_env << 16) / norm_env;
                if (lvl > 64'hFFFF) lvl = 64'hFFFF;
            end
            level_q.push_back(lvl[15:0]);
            energy_q.push_back(e[30:0]);
        endfunction

        function void check_result(logic [15:0] lvl, logic [30:0] en);
            logic [15:0] want_lvl;
            logic [30:0] want_en;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: level %0d energy %0d", lvl, en);
                return;
            end
            want_lvl = level_q.pop_front();
            want_en = energy_q.pop_front();
            if (lvl !== want_lvl || en !== want_en) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: level exp %0d got %0d, energy exp %0d got %0d",
                             $realtime, want_lvl, lvl, want_en, en);
            end
        endfunction

        function int pending();
            return level_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_audio_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_transient_level;
    logic [30:0] m_raw_energy;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    detector_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic signed [15:0] prev_smp = '0;

    always #4 aclk = ~aclk;

    multiband_transient_detector_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_audio_sample(s_audio_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_transient_level(m_transient_level),
        .m_raw_energy(m_raw_energy),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_sample(s_audio_sample);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_transient_level, m_raw_energy);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The write enable stays high until the next sample is driven, so back-to-back
    // register writes hold it high without a gap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic send_sample(input logic signed [15:0] smp);
        cfg_we <= 1'b0;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 90 : 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_audio_sample <= smp;
        prev_smp = smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Random full-scale, small and repeated samples, so the peak followers see real transients.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0, 1: return 16'($urandom);
            2:    return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
            3, 4: return $signed(16'($urandom_range(511))) - 16'sd256;
            5, 6: return prev_smp;
            7:    return -prev_smp;
            default: return $signed(16'($urandom_range(8191))) - 16'sd4096;
        endcase
    endfunction

    function automatic logic [23:0] pick_decay();
        case ($urandom_range(5))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'hFFFFFF - 24'($urandom_range(70000));
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        sb.clear();
        @(posedge aclk);

        // Default registers: full-scale extremes, steps and alternation.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        repeat (4) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain();

        // No slow weight, instant fast and norm followers; alternating full scale drives energy
        // into saturation, then silence with a zero normalization decay empties the divisor.
        write_reg(REG_FAST_DECAY, 24'd0);
        write_reg(REG_SLOW_DECAY, 24'hFFFFFF);
        write_reg(REG_SMOOTH_DECAY, 24'hFFFFFF);
        write_reg(REG_NORM_DECAY, 24'd0);
        write_reg(REG_SLOW_WEIGHT, 24'd0);
        write_reg(3'd5, 24'hFFFFFF);
        write_reg(3'd7, 24'd0);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
        repeat (5) send_sample(16'sh0000);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            write_reg(REG_FAST_DECAY, pick_decay());
            write_reg(REG_SLOW_DECAY, pick_decay());
            write_reg(REG_SMOOTH_DECAY, pick_decay());
            write_reg(REG_NORM_DECAY, pick_decay());
            case (p % 3)
                0: write_reg(REG_SLOW_WEIGHT, 24'hFFFF);
                1: write_reg(REG_SLOW_WEIGHT, 24'($urandom_range(65535)));
                default: write_reg(REG_SLOW_WEIGHT, 24'd0);
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                send_sample(pick_sample());
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS multiband_transient_detector_core");
        end else begin
            $display("FAIL multiband_transient_detector_core");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("FAIL multiband_transient_detector_core");
        $finish;
    end

endmodule

>>> multiband_transient_detector_core.f
hdl/mtd_pkg.sv
hdl/mtd_controller.sv
hdl/mtd_datapath.sv
hdl/multiband_transient_detector_core.sv
bench/tb_top.sv
